// ----- sv/uot_pkg.sv -----
// ----------------------------------------------------------------------------
// uot_pkg: shared types and constants of the unspent output table
// Entry layout, operation and status codes, and default table depth.
// ----------------------------------------------------------------------------
package uot_pkg;

  localparam int DefEntries = 64;
  localparam int SlotW      = 6;
  localparam int InDataW    = 416;
  localparam int OutDataW   = 328;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_BALANCE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

  typedef struct packed {
    logic [63:0] amount;
    logic [63:0] owner3;
    logic [63:0] owner2;
    logic [63:0] owner1;
    logic [63:0] owner0;
    logic [31:0] outi;
    logic [63:0] blk;
  } entry_t;

  // Control from the sequencer to the head unit.
  typedef struct packed {
    logic start;
    logic step;
  } scan_ctl_t;

endpackage

// ----- sv/unspent_output_table.sv -----
// ----------------------------------------------------------------------------
// unspent_output_table: fixed table of unspent outputs
// Insert, remove, lookup and owner balance over a rotating row of slots.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one request per beat. s_tuser holds the operation
// (insert, remove, lookup, balance) and s_tdata the key, owner key and amount.
// The master stream returns exactly one result beat per request, with the
// status in m_tuser and slot, amount and owner key in m_tdata.
// The slots form a ring of cells that rotates by one position per cycle
// while a request is served; the head unit sees slot k at scan step k, so
// after ENTRIES steps every slot has been inspected and the ring is back in
// its original order. A request is accepted, the ring then rotates through
// ENTRIES scan steps, and the result then goes to the output register. The
// scan length is set by the top-level sequencer, not the single head unit.
// A new request is accepted while the previous result still waits in the
// output register; if the receiver stalls, the finished scan waits until the
// output register is free. Reset clears every slot amount, so all slots are
// free and no result is pending.
// ----------------------------------------------------------------------------
module unspent_output_table
  import uot_pkg::*;
#(
  parameter int ENTRIES = DefEntries
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // block_index[63:0], output_index[95:64], owner_word0..3[351:96],
  // value_in[415:352]
  input  logic [InDataW-1:0]  s_tdata,
  // kind[1:0]
  input  logic [1:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // slot[5:0], value_out[69:6], found_word0..3[325:70], zero pad [327:326]
  output logic [OutDataW-1:0] m_tdata,
  // status[1:0]
  output logic [1:0]          m_tuser
);

  localparam int IdxW = $clog2(ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t          state;
  logic [IdxW-1:0] pos;
  scan_ctl_t       ctl;
  entry_t          req_in;
  entry_t          ring [ENTRIES];
  entry_t          tail;
  status_t         res_status;
  logic [SlotW-1:0] res_slot;
  logic [63:0]     res_value;
  logic [255:0]    res_owner;
  logic            out_free;

  assign s_tready  = (state == S_IDLE);
  assign ctl.start = s_tvalid && s_tready;
  assign ctl.step  = (state == S_SCAN);
  assign out_free  = !m_tvalid || m_tready;

  assign req_in.blk    = s_tdata[63:0];
  assign req_in.outi   = s_tdata[95:64];
  assign req_in.owner0 = s_tdata[159:96];
  assign req_in.owner1 = s_tdata[223:160];
  assign req_in.owner2 = s_tdata[287:224];
  assign req_in.owner3 = s_tdata[351:288];
  assign req_in.amount = s_tdata[415:352];

  // Ring of slots: each cell takes its upper neighbor, the top cell takes the
  // possibly rewritten head entry.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t din;
    if (i == ENTRIES - 1) begin : g_top
      assign din = tail;
    end else begin : g_mid
      assign din = ring[i+1];
    end
    uot_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ctl.step),
      .din   (din),
      .dout  (ring[i])
    );
  end

  uot_scan #(
    .IdxW (IdxW)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .pos        (pos),
    .op_in      (op_t'(s_tuser)),
    .req_in     (req_in),
    .head       (ring[0]),
    .tail       (tail),
    .res_status (res_status),
    .res_slot   (res_slot),
    .res_value  (res_value),
    .res_owner  (res_owner)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pos      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // In the done state a taken beat is replaced by the new result below.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (ctl.start) begin
            state <= S_SCAN;
            pos   <= '0;
          end
        end
        S_SCAN: begin
          if (pos == IdxW'(ENTRIES - 1)) begin
            state <= S_DONE;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state    <= S_IDLE;
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {2'b00, res_owner, res_value, res_slot};
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/uot_cell.sv -----
// ----------------------------------------------------------------------------
// uot_cell: one table slot in the rotating row
// Holds one entry and takes its neighbor's entry on every scan step.
// ----------------------------------------------------------------------------
module uot_cell
  import uot_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  entry_t din,
  output entry_t dout
);

  entry_t ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.amount <= '0;
    end else if (shift) begin
      ent <= din;
    end
  end

  assign dout = ent;

endmodule

// ----- sv/uot_scan.sv -----
// ----------------------------------------------------------------------------
// uot_scan: head unit of the rotating row
// Inspects the entry at the head, rewrites it on its way to the tail and
// gathers the result of the running operation.
// ----------------------------------------------------------------------------
module uot_scan
  import uot_pkg::*;
#(
  parameter int IdxW = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  scan_ctl_t       ctl,
  input  logic [IdxW-1:0] pos,
  input  op_t             op_in,
  input  entry_t          req_in,
  input  entry_t          head,
  output entry_t          tail,
  output status_t         res_status,
  output logic [SlotW-1:0] res_slot,
  output logic [63:0]     res_value,
  output logic [255:0]    res_owner
);

  op_t              op;
  entry_t           req;
  logic             done;
  logic             sat;
  logic [63:0]      sum;
  logic [SlotW-1:0] slot;
  logic [63:0]      value;
  logic [255:0]     owner;

  logic        key_hit;
  logic        owner_hit;
  logic [64:0] add;

  assign key_hit   = (head.amount != '0) && (head.blk == req.blk) && (head.outi == req.outi);
  assign owner_hit = ({head.owner3, head.owner2, head.owner1, head.owner0} ==
                      {req.owner3, req.owner2, req.owner1, req.owner0});
  assign add       = {1'b0, sum} + {1'b0, head.amount};

  always_comb begin
    tail = head;
    if (!done) begin
      if (op == OP_INSERT && head.amount == '0) begin
        tail = req;
      end else if (op == OP_REMOVE && key_hit) begin
        tail = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op   <= OP_INSERT;
      done <= 1'b0;
      sat  <= 1'b0;
    end else if (ctl.start) begin
      op    <= op_in;
      req   <= req_in;
      done  <= 1'b0;
      sat   <= 1'b0;
      sum   <= '0;
      slot  <= '0;
      value <= '0;
      owner <= '0;
    end else if (ctl.step) begin
      unique case (op)
        OP_INSERT: begin
          if (!done && head.amount == '0) begin
            done <= 1'b1;
            slot <= SlotW'(pos);
          end
        end
        OP_REMOVE: begin
          if (!done && key_hit) begin
            done <= 1'b1;
            slot <= SlotW'(pos);
          end
        end
        OP_LOOKUP: begin
          if (!done && key_hit) begin
            done  <= 1'b1;
            slot  <= SlotW'(pos);
            value <= head.amount;
            owner <= {head.owner3, head.owner2, head.owner1, head.owner0};
          end
        end
        OP_BALANCE: begin
          if (owner_hit) begin
            if (add[64]) begin
              sat <= 1'b1;
              sum <= '1;
            end else begin
              sum <= add[63:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_slot   = slot;
    res_value  = value;
    res_owner  = owner;
    unique case (op)
      OP_INSERT: if (!done) res_status = ST_FULL;
      OP_REMOVE, OP_LOOKUP: if (!done) res_status = ST_NOT_FOUND;
      OP_BALANCE: begin
        res_status = sat ? ST_SATURATED : ST_OK;
        res_value  = sum;
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/uot_checker.sv -----
// ----------------------------------------------------------------------------
// uot_checker: port-level checks of the unspent output table
// Watches both streams and the result codes over time.
// ----------------------------------------------------------------------------
module uot_checker
  import uot_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata,
  input logic [1:0]          m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted during a scan");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |-> m_tdata == '0)
    else $error("full result carries data");

  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_NOT_FOUND |-> m_tdata == '0)
    else $error("not-found result carries data");

endmodule

bind unspent_output_table uot_checker u_uot_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
